[src/chc_pkg.sv]
package chc_pkg;

  localparam int unsigned ENTRY_CAPACITY_DEF = 4096;
  localparam int unsigned NUM_BUCKETS_DEF    = 2048;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_ADD    = 3'd1,
    OP_INSERT = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  // Classified operation handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [63:0] amount;
    logic [11:0] slot_index;
    logic [63:0] hash;
  } chc_op_t;

endpackage

[src/chc_front.sv]
// Hash unit: splitmix64 finalizer, each 64-bit multiply split into three 32x32
// partial products and a combining add.
module chc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       opcode,
  input  logic [31:0]      key,
  input  logic [63:0]      amount,
  input  logic [11:0]      slot_index,
  output logic             op_valid,
  input  logic             op_ready,
  output chc_pkg::chc_op_t op_data
);
  import chc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_M1, S_M1B, S_M2, S_M2B, S_M2C, S_DONE} fstate_t;

  fstate_t     state_r;
  chc_op_t     op_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;

  // Low 64 bits of a*b built from three 32x32 products, registered before the combining add.
  logic [63:0] mul_c;
  logic [63:0] lo_prod;
  logic [31:0] cross_a;
  logic [31:0] cross_b;
  logic [63:0] acc_sum;
  logic [63:0] x1;

  assign mul_c   = (state_r == S_M1) ? MIX_C1 : MIX_C2;
  assign lo_prod = {32'd0, x_r[31:0]} * {32'd0, mul_c[31:0]};
  assign cross_a = x_r[31:0] * mul_c[63:32];
  assign cross_b = x_r[63:32] * mul_c[31:0];
  assign acc_sum = acc_r + {x_r[63:32] + x_r[31:0], 32'd0};
  assign x1      = acc_r ^ (acc_r >> 27);

  assign in_ready = (state_r == S_IDLE);
  assign op_valid = (state_r == S_DONE);
  assign op_data  = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r.opcode     <= opcode;
            op_r.key        <= key;
            op_r.amount     <= amount;
            op_r.slot_index <= slot_index;
            // key < 2^32 so x ^ (x >> 30) only touches low bits
            x_r     <= {32'd0, key} ^ ({32'd0, key} >> 30);
            state_r <= S_M1;
          end
        end
        S_M1: begin
          acc_r   <= lo_prod;
          x_r     <= {cross_a, cross_b};
          state_r <= S_M1B;
        end
        S_M1B: begin
          acc_r   <= acc_sum;
          state_r <= S_M2;
        end
        S_M2: begin
          x_r     <= x1;
          state_r <= S_M2B;
        end
        S_M2B: begin
          acc_r   <= lo_prod;
          x_r     <= {cross_a, cross_b};
          state_r <= S_M2C;
        end
        S_M2C: begin
          op_r.hash <= acc_sum ^ (acc_sum >> 31);
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (op_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[src/chc_back.sv]
module chc_back #(
  parameter int unsigned ENTRY_CAPACITY = chc_pkg::ENTRY_CAPACITY_DEF,
  parameter int unsigned NUM_BUCKETS    = chc_pkg::NUM_BUCKETS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  output logic             op_ready,
  input  chc_pkg::chc_op_t op_data,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [111:0]     res_data
);
  import chc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRY_CAPACITY);
  localparam int unsigned BW = $clog2(NUM_BUCKETS);
  localparam int unsigned LW = AW + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_HEADW, S_WALK, S_WALKW, S_ADDW, S_READW, S_READD, S_OUT
  } bstate_t;

  logic [LW-1:0] heads_mem [NUM_BUCKETS];
  logic [31:0]   keys_mem  [ENTRY_CAPACITY];
  logic [63:0]   cnt_mem   [ENTRY_CAPACITY];
  logic [LW-1:0] link_mem  [ENTRY_CAPACITY];

  bstate_t       state_r;
  chc_op_t       op_r;
  logic [BW-1:0] clr_r;
  logic [LW-1:0] used_r;
  logic [LW-1:0] pos_r;
  logic [LW-1:0] steps_r;
  logic [LW-1:0] head_q;
  logic [31:0]   key_q;
  logic [63:0]   cnt_q;
  logic [LW-1:0] link_q;
  logic          found_r;
  logic [63:0]   count_r;
  logic [31:0]   keyo_r;
  logic [1:0]    status_r;

  logic [BW-1:0] bucket;
  logic [64:0]   sum;
  assign bucket = op_r.hash[BW-1:0];
  assign sum    = {1'b0, cnt_q} + {1'b0, op_r.amount};

  assign op_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_data  = {status_r, 13'(used_r), keyo_r, count_r, found_r};

  always_ff @(posedge clk) begin
    head_q <= heads_mem[bucket];
    key_q  <= keys_mem[pos_r[AW-1:0]];
    cnt_q  <= cnt_mem[pos_r[AW-1:0]];
    link_q <= link_mem[pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      used_r  <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          heads_mem[clr_r] <= LW'(ENTRY_CAPACITY);
          clr_r <= clr_r + BW'(1);
          if (clr_r == BW'(NUM_BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (op_valid) begin
            op_r     <= op_data;
            found_r  <= 1'b0;
            count_r  <= '0;
            keyo_r   <= '0;
            status_r <= ST_OK;
            steps_r  <= '0;
            unique case (op_data.opcode) inside
              OP_LOOKUP, OP_ADD: state_r <= S_HEAD;
              OP_INSERT: begin
                if (used_r >= LW'(ENTRY_CAPACITY)) begin
                  status_r <= ST_FULL;
                  state_r  <= S_OUT;
                end else state_r <= S_HEAD;
              end
              OP_READ: begin
                if ({1'b0, op_data.slot_index} < 13'(used_r) && LW'(op_data.slot_index) <
                    LW'(ENTRY_CAPACITY)) begin
                  pos_r   <= LW'(op_data.slot_index);
                  state_r <= S_READW;
                end else begin
                  status_r <= ST_BAD_INDEX;
                  state_r  <= S_OUT;
                end
              end
              OP_CLEAR: begin
                // report first, sweep the heads once the result is taken
                used_r  <= '0;
                clr_r   <= '0;
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_HEAD: state_r <= S_HEADW;
        S_HEADW: begin
          if (op_r.opcode == OP_INSERT) begin
            keys_mem[used_r[AW-1:0]] <= op_r.key;
            cnt_mem[used_r[AW-1:0]]  <= op_r.amount;
            link_mem[used_r[AW-1:0]] <= head_q;
            heads_mem[bucket]        <= used_r;
            used_r  <= used_r + LW'(1);
            count_r <= op_r.amount;
            state_r <= S_OUT;
          end else begin
            pos_r   <= head_q;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (pos_r < used_r && steps_r < used_r) state_r <= S_WALKW;
          else state_r <= S_OUT;
        end
        S_WALKW: state_r <= S_ADDW;
        S_ADDW: begin
          if (key_q == op_r.key) begin
            found_r <= 1'b1;
            if (op_r.opcode == OP_ADD) begin
              if (sum[64]) begin
                status_r <= ST_OVERFLOW;
                count_r  <= cnt_q;
              end else begin
                cnt_mem[pos_r[AW-1:0]] <= sum[63:0];
                count_r <= sum[63:0];
              end
            end else count_r <= cnt_q;
            state_r <= S_OUT;
          end else begin
            pos_r   <= link_q;
            steps_r <= steps_r + LW'(1);
            state_r <= S_WALK;
          end
        end
        S_READW: state_r <= S_READD;
        S_READD: begin
          found_r <= 1'b1;
          keyo_r  <= key_q;
          count_r <= cnt_q;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) state_r <= (op_r.opcode == OP_CLEAR) ? S_CLR : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[src/chained_hash_count_table.sv]
// Chained hash count table: 32-bit keys with 64-bit counts, chained buckets.
// Input channel in_*: one operation word; tdata = opcode[2:0], key[34:3],
// amount[98:35], slot_index[110:99]. Output channel out_*: one result word per
// operation; tdata = found[0], count_out[64:1], key_out[96:65],
// entries_used[109:97], status[111:110].
// The front hashes the key with a split 64-bit multiply; the back walks the
// bucket chain in memory, one chain entry at a time. The front may hash the
// next word while the back works, so up to two operations are in flight;
// results come out in order.
// After reset and after a clear result is taken the bucket heads are swept to
// null, one per cycle; the back takes no operation then, while the front may
// accept and hold one word.
// A stalled receiver holds the result word; the block then takes at most one
// more word and holds in_tready low.
module chained_hash_count_table #(
  parameter int unsigned ENTRY_CAPACITY = chc_pkg::ENTRY_CAPACITY_DEF,
  parameter int unsigned NUM_BUCKETS    = chc_pkg::NUM_BUCKETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // opcode, key, amount, slot_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // found, count_out, key_out, entries_used, status
);
  import chc_pkg::*;

  logic    op_valid;
  logic    op_ready;
  chc_op_t op_data;

  chc_front u_front (
    .clk, .rst_n,
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .opcode    (in_tdata[2:0]),
    .key       (in_tdata[34:3]),
    .amount    (in_tdata[98:35]),
    .slot_index(in_tdata[110:99]),
    .op_valid, .op_ready, .op_data
  );

  chc_back #(.ENTRY_CAPACITY(ENTRY_CAPACITY), .NUM_BUCKETS(NUM_BUCKETS)) u_back (
    .clk, .rst_n, .op_valid, .op_ready, .op_data,
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_data (out_tdata)
  );
endmodule

[verif/chained_hash_count_table_checker.sv]
`timescale 1ns / 100ps
module chained_hash_count_table_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  import chc_pkg::*;

  localparam int unsigned NIL = ENTRY_CAPACITY_DEF;
  localparam int unsigned BMASK = NUM_BUCKETS_DEF - 1;

  // laid out as out_tdata, status in the top bits down to found at bit 0
  typedef struct packed {
    status_t     status;
    logic [12:0] entries_used;
    logic [31:0] key_out;
    logic [63:0] count_out;
    logic        found;
  } tally_t;

  int unsigned heads[NUM_BUCKETS_DEF];
  logic [31:0] keys_mem[ENTRY_CAPACITY_DEF];
  logic [63:0] counts_mem[ENTRY_CAPACITY_DEF];
  int unsigned links_mem[ENTRY_CAPACITY_DEF];
  int unsigned used;
  tally_t tally_q[$];

  function automatic int unsigned bucket_for(logic [31:0] k);
    logic [63:0] x;
    x = {32'd0, k};
    x = x ^ (x >> 30);
    x = x * 64'hbf58476d1ce4e5b9;
    x = x ^ (x >> 27);
    x = x * 64'h94d049bb133111eb;
    x = x ^ (x >> 31);
    return int'(x[31:0] & BMASK);
  endfunction

  function automatic int unsigned locate(logic [31:0] k);
    int unsigned p;
    int unsigned steps;
    p = heads[bucket_for(k)];
    steps = 0;
    while (p < used && steps < used) begin
      if (keys_mem[p] == k) return p;
      p = links_mem[p];
      steps++;
    end
    return NIL;
  endfunction

  function automatic tally_t apply_op(logic [111:0] w);
    tally_t t;
    logic [2:0] op;
    logic [31:0] k;
    logic [63:0] amt;
    int unsigned slot;
    int unsigned p;
    int unsigned b;
    op = w[2:0];
    k = w[34:3];
    amt = w[98:35];
    slot = 32'(w[110:99]);
    t = '0;
    t.status = ST_OK;
    case (op)
      OP_LOOKUP: begin
        p = locate(k);
        if (p != NIL) begin
          t.found = 1'b1;
          t.count_out = counts_mem[p];
        end
      end
      OP_ADD: begin
        p = locate(k);
        if (p != NIL) begin
          t.found = 1'b1;
          if (64'hffff_ffff_ffff_ffff - counts_mem[p] < amt) t.status = ST_OVERFLOW;
          else counts_mem[p] = counts_mem[p] + amt;
          t.count_out = counts_mem[p];
        end
      end
      OP_INSERT: begin
        if (used >= ENTRY_CAPACITY_DEF) begin
          t.status = ST_FULL;
        end else begin
          b = bucket_for(k);
          keys_mem[used] = k;
          counts_mem[used] = amt;
          links_mem[used] = heads[b];
          heads[b] = used;
          used++;
          t.count_out = amt;
        end
      end
      OP_READ: begin
        if (slot < used) begin
          t.found = 1'b1;
          t.key_out = keys_mem[slot];
          t.count_out = counts_mem[slot];
        end else begin
          t.status = ST_BAD_INDEX;
        end
      end
      OP_CLEAR: begin
        foreach (heads[i]) heads[i] = NIL;
        used = 0;
      end
      default: ;
    endcase
    t.entries_used = used[12:0];
    return t;
  endfunction

  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (!rst_n) begin
      foreach (heads[i]) heads[i] = NIL;
      used = 0;
      tally_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) tally_q.push_back(apply_op(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (tally_q.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = tally_q.pop_front();
          if (got != want) begin
            if (got.found != want.found)
              $error("found: expected %0d actual %0d", want.found, got.found);
            if (got.count_out != want.count_out)
              $error("count_out: expected %h actual %h", want.count_out, got.count_out);
            if (got.key_out != want.key_out)
              $error("key_out: expected %h actual %h", want.key_out, got.key_out);
            if (got.entries_used != want.entries_used)
              $error("entries_used: expected %0d actual %0d",
                     want.entries_used, got.entries_used);
            if (got.status != want.status)
              $error("status: expected %0d actual %0d", want.status, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= tally_q.size();
    end
  end

endmodule

[verif/chained_hash_count_table_tb.sv]
`timescale 1ns / 100ps
module chained_hash_count_table_tb;
  import chc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic         hold_req;
  int           hold_left;
  int           quiet_cycles;
  logic [31:0]  known_keys[$];

  chained_hash_count_table uut (.*);

  chained_hash_count_table_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall, or one long hold-off once asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 300;
    end else if (hold_req && hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [111:0] pack_op(opcode_t op, logic [31:0] k, logic [63:0] amt,
                                           logic [11:0] slot);
    return {1'b0, slot, amt, k, op};
  endfunction

  // valid stays high after acceptance until the next word or an idle cycle
  task automatic send_word(logic [111:0] w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(99) < 70)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom_range(3) == 0 ? $urandom_range(15) : $urandom;
  endfunction

  task automatic random_op();
    int r;
    logic [31:0] k;
    logic [63:0] amt;
    r = $urandom_range(99);
    k = pick_key();
    amt = $urandom_range(3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(1000));
    if (r < 30) begin
      known_keys.push_back(k);
      send_word(pack_op(OP_INSERT, k, amt, 12'($urandom)));
    end else if (r < 55) begin
      send_word(pack_op(OP_ADD, k, amt, 12'($urandom)));
    end else if (r < 75) begin
      send_word(pack_op(OP_LOOKUP, k, amt, 12'($urandom)));
    end else if (r < 94) begin
      send_word(pack_op(OP_READ, k, amt,
                        $urandom_range(1) ? 12'($urandom_range(40)) : 12'($urandom)));
    end else if (r < 96) begin
      known_keys.delete();
      send_word(pack_op(OP_CLEAR, k, amt, 12'($urandom)));
    end else begin
      send_word(pack_op(opcode_t'(3'($urandom_range(7, 5))), k, amt, 12'($urandom)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, overflow, shadowing, bad index, clear
    send_word(pack_op(OP_LOOKUP, 32'hffff_ffff, '0, '0));
    send_word(pack_op(OP_READ, '0, '0, 12'd0));
    send_word(pack_op(OP_INSERT, 32'd0, 64'hffff_ffff_ffff_fffe, 12'hfff));
    send_word(pack_op(OP_INSERT, 32'hffff_ffff, 64'd0, '0));
    send_word(pack_op(OP_ADD, 32'd0, 64'd1, '0));
    send_word(pack_op(OP_ADD, 32'd0, 64'd1, '0));
    send_word(pack_op(OP_ADD, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, '0));
    send_word(pack_op(OP_ADD, 32'd7, 64'd5, '0));
    send_word(pack_op(OP_INSERT, 32'd0, 64'd42, '0));
    send_word(pack_op(OP_LOOKUP, 32'd0, '0, '0));
    send_word(pack_op(OP_READ, '0, '0, 12'd0));
    send_word(pack_op(OP_READ, '0, '0, 12'd2));
    send_word(pack_op(OP_READ, '0, '0, 12'd3));
    send_word(pack_op(OP_READ, '0, '0, 12'hfff));
    send_word(pack_op(opcode_t'(3'd5), 32'h1234, 64'd9, 12'd1));
    send_word(pack_op(opcode_t'(3'd7), '1, '1, '1));
    send_word(pack_op(OP_CLEAR, '0, '0, '0));
    send_word(pack_op(OP_LOOKUP, 32'd0, '0, '0));
    send_word(pack_op(OP_READ, '0, '0, 12'd0));
    send_word(pack_op(OP_INSERT, 32'h8000_0001, 64'h8000_0000_0000_0000, '0));
    send_word(pack_op(OP_ADD, 32'h8000_0001, 64'h8000_0000_0000_0000, '0));

    // long receiver hold-off while words keep coming
    hold_req <= 1'b1;
    repeat (8) random_op();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 45) : 0;
      recv_idle_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 45) : 0;
      repeat (155) random_op();
    end
    in_tvalid <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[chained_hash_count_table.f]
src/chc_pkg.sv
src/chc_front.sv
src/chc_back.sv
src/chained_hash_count_table.sv
verif/chained_hash_count_table_checker.sv
verif/chained_hash_count_table_tb.sv
